[rtl/cba_pkg.sv]
package cba_pkg;

  // Default geometry of the free map.
  localparam int NBLOCKS_DEF   = 256;
  localparam int WORD_BITS_DEF = 16;

  // Block count register width and its value after reset.
  localparam int          TOTAL_W     = 9;
  localparam logic [8:0]  TOTAL_RESET = 9'd256;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] first_block;
    logic [8:0] run_length;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] run_start;
    logic [8:0] free_blocks;
  } out_t;

endpackage

[rtl/cba_ram.sv]
module cba_ram
  import cba_pkg::*;
#(
  parameter int WIDTH = WORD_BITS_DEF,
  parameter int DEPTH = NBLOCKS_DEF / WORD_BITS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/contiguous_block_allocator.sv]
// Channel   Ports                          Transfer
// input     start, busy, in_data           start high while busy is low
// result    out_strobe, out_data           out_strobe high for one cycle
// config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready both high
//
// The free map sits in one RAM of MAP_WORDS words, read and written one word a cycle.
// An allocation primes the read (S_SCAN_RD), then scans words from the bottom (S_SCAN)
// until a fitting run is found, then rewrites words from the bottom to the run's end.
// A free request only does the rewrite pass. If no run fits, a no-space result is given.
// Zero-length and oversize requests are answered from idle without a pass.
// After reset and after each block count write a clearing pass over MAP_WORDS words sets
// every block free; busy stays high meanwhile. Results cannot be held off by the receiver.
module contiguous_block_allocator
  import cba_pkg::*;
#(
  parameter int NBLOCKS   = NBLOCKS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_data,
  output logic               out_strobe,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TOTAL_W-1:0] cfg_data
);

  localparam int MAP_WORDS = (NBLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(MAP_WORDS * WORD_BITS + 1024 + 1);
  localparam int JW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int DW        = $clog2(WORD_BITS + 1);
  localparam int NB_CAP    = (NBLOCKS > 511) ? 511 : NBLOCKS;

  localparam logic [AW-1:0]      LAST_ADDR = AW'(MAP_WORDS - 1);
  localparam logic [TOTAL_W-1:0] CAP_VAL   = TOTAL_W'(NB_CAP);

  // Controller states.
  localparam logic [2:0] S_CLR      = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_APPLY_RD = 3'd4;
  localparam logic [2:0] S_APPLY    = 3'd5;

  function automatic logic [TOTAL_W-1:0] eff_count(input logic [TOTAL_W-1:0] v);
    eff_count = (v > CAP_VAL) ? CAP_VAL : v;
  endfunction

  logic [2:0]           state_r,  state_nxt;
  logic [AW-1:0]        addr_r,   addr_nxt;
  logic [PW-1:0]        base_r,   base_nxt;
  logic [PW-1:0]        run_r,    run_nxt;
  logic [PW-1:0]        lo_r,     lo_nxt;
  logic [PW-1:0]        hi_r,     hi_nxt;
  logic                 set_r,    set_nxt;
  logic                 kind_r,   kind_nxt;
  logic [8:0]           len_r,    len_nxt;
  logic [TOTAL_W-1:0]   total_r,  total_nxt;
  logic [8:0]           ft_r,     ft_nxt;
  logic                 strobe_r, strobe_nxt;
  out_t                 out_r,    out_nxt;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [PW-1:0]        limit;
  logic                 cfg_xfer;
  logic                 in_xfer;

  // Word evaluation results.
  logic [WORD_BITS-1:0] fr;
  logic                 hit;
  logic [JW-1:0]        hit_pos;
  logic [PW-1:0]        run_out;
  logic [PW-1:0]        hit_start;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] new_word;
  logic [DW-1:0]        delta;
  logic [8:0]           ft_applied;

  assign limit     = PW'(eff_count(total_r));
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLR);
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign busy      = (state_r != S_IDLE) || cfg_valid;
  assign in_xfer   = start && !busy;

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  cba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  // Run search over one word: run length ending at each bit, first bit that completes it.
  always_comb begin
    logic [PW-1:0] pos;
    logic [PW-1:0] run_j;
    logic          zero_seen;
    int            last;
    fr        = '0;
    hit       = 1'b0;
    hit_pos   = '0;
    run_out   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pos   = base_r + PW'(j);
      fr[j] = ram_rdata[j] && (pos < limit);
    end
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      zero_seen = 1'b0;
      last      = 0;
      for (int k = 0; k <= j; k++) begin
        if (!fr[k]) begin
          zero_seen = 1'b1;
          last      = k;
        end
      end
      run_j = zero_seen ? PW'(j - last) : run_r + PW'(j + 1);
      if (j == WORD_BITS - 1) begin
        run_out = run_j;
      end
      if (run_j >= PW'(len_r)) begin
        hit     = 1'b1;
        hit_pos = JW'(j);
      end
    end
    hit_start = base_r + PW'(hit_pos) + PW'(1) - PW'(len_r);
  end

  // Range update of one word and the number of blocks that change.
  always_comb begin
    logic [PW-1:0] pos;
    logic [WORD_BITS-1:0] flip;
    mask = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pos     = base_r + PW'(j);
      mask[j] = (pos >= lo_r) && (pos < hi_r);
    end
    new_word = set_r ? (ram_rdata | mask) : (ram_rdata & ~mask);
    flip     = mask & (set_r ? ~ram_rdata : ram_rdata);
    delta    = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      delta = delta + DW'(flip[j]);
    end
    ft_applied = set_r ? (ft_r + 9'(delta)) : (ft_r - 9'(delta));
  end

  // Controller.
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    base_nxt   = base_r;
    run_nxt    = run_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    set_nxt    = set_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    total_nxt  = total_r;
    ft_nxt     = ft_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    ram_we     = 1'b0;
    ram_wdata  = new_word;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
          addr_nxt  = '0;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        addr_nxt = '0;
        base_nxt = '0;
        run_nxt  = '0;
        if (in_xfer) begin
          kind_nxt = in_data.kind;
          len_nxt  = in_data.run_length;
          if (in_data.run_length == 9'd0) begin
            strobe_nxt = 1'b1;
            out_nxt    = '{status: ST_BAD, run_start: 8'd0, free_blocks: ft_r};
          end else if (in_data.kind == KIND_ALLOC) begin
            if (PW'(in_data.run_length) > limit) begin
              strobe_nxt = 1'b1;
              out_nxt    = '{status: ST_NOSPACE, run_start: 8'd0, free_blocks: ft_r};
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end else begin
            if (PW'(in_data.first_block) + PW'(in_data.run_length) > limit) begin
              strobe_nxt = 1'b1;
              out_nxt    = '{status: ST_BAD, run_start: 8'd0, free_blocks: ft_r};
            end else begin
              lo_nxt    = PW'(in_data.first_block);
              hi_nxt    = PW'(in_data.first_block) + PW'(in_data.run_length);
              set_nxt   = 1'b1;
              state_nxt = S_APPLY_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          lo_nxt    = hit_start;
          hi_nxt    = hit_start + PW'(len_r);
          set_nxt   = 1'b0;
          addr_nxt  = '0;
          base_nxt  = '0;
          state_nxt = S_APPLY_RD;
        end else if ((addr_r == LAST_ADDR) || (base_r + PW'(WORD_BITS) >= limit)) begin
          strobe_nxt = 1'b1;
          out_nxt    = '{status: ST_NOSPACE, run_start: 8'd0, free_blocks: ft_r};
          state_nxt  = S_IDLE;
          addr_nxt   = '0;
        end else begin
          run_nxt  = run_out;
          addr_nxt = addr_r + AW'(1);
          base_nxt = base_r + PW'(WORD_BITS);
        end
      end
      S_APPLY_RD: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        ram_we = 1'b1;
        ft_nxt = ft_applied;
        if ((addr_r == LAST_ADDR) || (base_r + PW'(WORD_BITS) >= hi_r)) begin
          strobe_nxt = 1'b1;
          out_nxt.status      = ST_OK;
          out_nxt.run_start   = (kind_r == KIND_ALLOC) ? lo_r[7:0] : 8'd0;
          out_nxt.free_blocks = ft_applied;
          state_nxt  = S_IDLE;
          addr_nxt   = '0;
        end else begin
          addr_nxt = addr_r + AW'(1);
          base_nxt = base_r + PW'(WORD_BITS);
        end
      end
      default: begin
        state_nxt = S_CLR;
        addr_nxt  = '0;
      end
    endcase

    // A block count write restarts the clearing pass.
    if (cfg_xfer) begin
      total_nxt = cfg_data;
      ft_nxt    = eff_count(cfg_data);
      state_nxt = S_CLR;
      addr_nxt  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      addr_r   <= '0;
      total_r  <= TOTAL_RESET;
      ft_r     <= eff_count(TOTAL_RESET);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      total_r  <= total_nxt;
      ft_r     <= ft_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    run_r  <= run_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    set_r  <= set_nxt;
    kind_r <= kind_nxt;
    len_r  <= len_nxt;
    out_r  <= out_nxt;
  end

endmodule
